// ----- rtl/lbwe_pkg.sv -----
// Package for the LED bit waveform encoder: field widths, register codes,
// reset values and the timing result bundle. No dependencies.
package lbwe_pkg;

  localparam int RATE_W    = 30;
  localparam int PHASE_W   = 16;
  localparam int TOTAL_W   = PHASE_W + 2;
  localparam int COUNT_W   = 6;
  localparam int PATTERN_W = 32;
  localparam int DIV_W     = 32;
  localparam int DSR_W     = 30;
  localparam int PROD_W    = PHASE_W + COUNT_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = RATE_W;

  localparam int MAX_PULSES_PER_BIT = 32;
  localparam int PULSE_LIMIT = (MAX_PULSES_PER_BIT < PATTERN_W) ? MAX_PULSES_PER_BIT
                                                                 : PATTERN_W;

  localparam logic [DIV_W-1:0]   NS_PER_SEC   = 32'd1000000000;
  localparam logic [RATE_W-1:0]  RATE_RST     = 30'd10000000;
  localparam logic [PHASE_W-1:0] FIRST_RST    = 16'd250;
  localparam logic [PHASE_W-1:0] MIDDLE_RST   = 16'd625;
  localparam logic [PHASE_W-1:0] LAST_RST     = 16'd375;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE   = 2'd0,
    REG_FIRST  = 2'd1,
    REG_MIDDLE = 2'd2,
    REG_LAST   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               ready;
    logic               invalid;
    logic [COUNT_W-1:0] ppb;
    logic [COUNT_W-1:0] zero_hi;
    logic [COUNT_W-1:0] one_hi;
  } timing_t;

endpackage

// ----- rtl/lbwe_if.sv -----
// Channel interfaces for the LED bit waveform encoder: byte input, pulse
// pattern output and register write. Depends on lbwe_pkg.
interface lbwe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
  modport monitor (input valid, input data_byte, input ready);
endinterface

interface lbwe_out_if import lbwe_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [PATTERN_W-1:0] pulse_pattern;
  logic [COUNT_W-1:0]   pulse_count;
  logic                 bit_value;
  logic                 last_of_byte;
  logic                 timing_error;

  modport source (output valid, output pulse_pattern, output pulse_count,
                  output bit_value, output last_of_byte, output timing_error,
                  input ready);
  modport sink (input valid, input pulse_pattern, input pulse_count,
                input bit_value, input last_of_byte, input timing_error,
                output ready);
  modport monitor (input valid, input pulse_pattern, input pulse_count,
                   input bit_value, input last_of_byte, input timing_error,
                   input ready);
endinterface

interface lbwe_cfg_if import lbwe_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
  modport monitor (input valid, input reg_index, input data, input ready);
endinterface

// ----- rtl/lbwe_div.sv -----
// Restoring divider, one quotient bit per cycle, for the timing setup.
// Depends on lbwe_pkg.
module lbwe_div import lbwe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic               run_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_W-1:0]   dvd_r;
  logic [DSR_W-1:0]   dsr_r;
  logic [DSR_W-1:0]   rem_r;
  logic [DSR_W:0]     rem_sh;
  logic               fits;
  logic [DSR_W:0]     rem_sub;

  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign fits    = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], fits};
      rem_r <= fits ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- rtl/lbwe_timing.sv -----
// Configuration registers and the sequencer that derives pulse counts from
// them through the shared divider. Depends on lbwe_pkg and lbwe_div.
module lbwe_timing import lbwe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  lbwe_cfg_if.sink cfg,
  output timing_t tim
);

  typedef enum logic [5:0] {
    ST_CHECK  = 6'b000001,
    ST_PERIOD = 6'b000010,
    ST_COUNT  = 6'b000100,
    ST_FIRST  = 6'b001000,
    ST_LAST   = 6'b010000,
    ST_DONE   = 6'b100000
  } seq_state_t;

  seq_state_t         state_r, state_nxt;
  timing_t            tim_r, tim_nxt;
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic [COUNT_W-1:0] p1_r, p1_nxt;
  logic [RATE_W-1:0]  rate_r;
  logic [PHASE_W-1:0] first_r, middle_r, last_r;
  logic [TOTAL_W-1:0] total;
  logic               cfg_we;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dvd, div_quo;
  logic [DSR_W-1:0]   div_dsr;
  logic [COUNT_W-1:0] rem_cnt;
  logic [COUNT_W-1:0] p3;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;
  assign total     = TOTAL_W'(first_r) + TOTAL_W'(middle_r) + TOTAL_W'(last_r);
  assign rem_cnt   = n_r - p1_r;
  assign p3        = (div_quo > DIV_W'(rem_cnt)) ? rem_cnt : div_quo[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RST;
      first_r  <= FIRST_RST;
      middle_r <= MIDDLE_RST;
      last_r   <= LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg.reg_index))
        REG_RATE:   rate_r   <= cfg.data;
        REG_FIRST:  first_r  <= cfg.data[PHASE_W-1:0];
        REG_MIDDLE: middle_r <= cfg.data[PHASE_W-1:0];
        REG_LAST:   last_r   <= cfg.data[PHASE_W-1:0];
        default:    rate_r   <= rate_r;
      endcase
    end
  end

  lbwe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    tim_nxt   = tim_r;
    n_nxt     = n_r;
    p1_nxt    = p1_r;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    unique case (state_r)
      ST_CHECK: begin
        if (rate_r == '0 || first_r == '0 || middle_r == '0 || last_r == '0) begin
          tim_nxt   = '{ready: 1'b1, invalid: 1'b1, default: '0};
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_dvd   = NS_PER_SEC;
          div_dsr   = DSR_W'(rate_r);
          state_nxt = ST_PERIOD;
        end
      end
      ST_PERIOD: begin
        if (div_done) begin
          if (div_quo == '0) begin
            tim_nxt   = '{ready: 1'b1, invalid: 1'b1, default: '0};
            state_nxt = ST_DONE;
          end else begin
            div_start = 1'b1;
            div_dvd   = DIV_W'(total) + DIV_W'(div_quo[DSR_W-1:1]);
            div_dsr   = div_quo[DSR_W-1:0];
            state_nxt = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (div_done) begin
          if (div_quo == '0 || div_quo > DIV_W'(PULSE_LIMIT)) begin
            tim_nxt   = '{ready: 1'b1, invalid: 1'b1, default: '0};
            state_nxt = ST_DONE;
          end else begin
            n_nxt     = div_quo[COUNT_W-1:0];
            div_start = 1'b1;
            div_dvd   = DIV_W'(PROD_W'(first_r) * PROD_W'(div_quo[COUNT_W-1:0]))
                        + DIV_W'(total[TOTAL_W-1:1]);
            div_dsr   = DSR_W'(total);
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (div_done) begin
          p1_nxt    = (div_quo > DIV_W'(n_r)) ? n_r : div_quo[COUNT_W-1:0];
          div_start = 1'b1;
          div_dvd   = DIV_W'(PROD_W'(last_r) * PROD_W'(n_r)) + DIV_W'(total[TOTAL_W-1:1]);
          div_dsr   = DSR_W'(total);
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        if (div_done) begin
          tim_nxt   = '{ready: 1'b1, invalid: 1'b0, ppb: n_r, zero_hi: p1_r,
                        one_hi: n_r - p3};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_DONE;
      end
      default: begin
        state_nxt = ST_CHECK;
      end
    endcase
    if (cfg_we) begin
      div_start     = 1'b0;
      tim_nxt.ready = 1'b0;
      state_nxt     = ST_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CHECK;
      tim_r   <= '{ready: 1'b0, invalid: 1'b1, default: '0};
    end else begin
      state_r <= state_nxt;
      tim_r   <= tim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r  <= n_nxt;
    p1_r <= p1_nxt;
  end

  assign tim = tim_r;

endmodule

// ----- rtl/lbwe_ser.sv -----
// Byte holding register, bit sequencer and output register that emit one
// pulse pattern per data bit. Depends on lbwe_pkg and the channel interfaces.
module lbwe_ser import lbwe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  timing_t    tim,
  lbwe_in_if.sink    in_ch,
  lbwe_out_if.source out_ch
);

  logic                 busy_r;
  logic [7:0]           byte_r;
  logic [2:0]           idx_r;
  logic                 out_valid_r;
  logic [PATTERN_W-1:0] pattern_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 bit_r;
  logic                 last_r;
  logic                 err_r;
  logic                 adv;
  logic                 last_bit;
  logic                 cur_bit;
  logic                 acc;
  logic [COUNT_W-1:0]   highs;
  logic [PATTERN_W-1:0] pattern;

  assign adv         = !out_valid_r || out_ch.ready;
  assign last_bit    = tim.invalid || idx_r == 3'd7;
  assign cur_bit     = byte_r[3'd7 - idx_r];
  assign in_ch.ready = tim.ready && (!busy_r || (adv && last_bit));
  assign acc         = in_ch.valid && in_ch.ready;
  assign highs       = cur_bit ? tim.one_hi : tim.zero_hi;

  always_comb begin
    for (int i = 0; i < PATTERN_W; i++) begin
      pattern[i] = COUNT_W'(i) < highs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        busy_r <= 1'b1;
      end else if (adv && busy_r && last_bit) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      byte_r <= in_ch.data_byte;
      idx_r  <= '0;
    end else if (adv && busy_r) begin
      idx_r <= idx_r + 1'b1;
    end
    if (adv && busy_r) begin
      if (tim.invalid) begin
        pattern_r <= '0;
        count_r   <= '0;
        bit_r     <= 1'b0;
        last_r    <= 1'b1;
        err_r     <= 1'b1;
      end else begin
        pattern_r <= pattern;
        count_r   <= tim.ppb;
        bit_r     <= cur_bit;
        last_r    <= idx_r == 3'd7;
        err_r     <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pulse_pattern = pattern_r;
  assign out_ch.pulse_count   = count_r;
  assign out_ch.bit_value     = bit_r;
  assign out_ch.last_of_byte  = last_r;
  assign out_ch.timing_error  = err_r;

endmodule

// ----- rtl/led_bit_waveform_encoder_top.sv -----
// Channel    | dir | payload
// in_ch      | in  | data_byte[7:0]
// out_ch     | out | pulse_pattern[31:0], pulse_count[5:0], bit_value,
//            |     | last_of_byte, timing_error
// cfg_ch     | in  | reg_index[1:0], data[29:0]; always ready
//
// A byte gives eight patterns, one per cycle while the output is not stalled;
// with a bad configuration it gives one error item. The bit sequencer and
// one output register set this rate. After reset and after every register
// write the divider runs up to four divisions while in_ch.ready stays low.
// A stalled output holds its item; the next byte is taken in the cycle its
// predecessor's last pattern moves to the output.
// Top level of the LED bit waveform encoder. Depends on lbwe_pkg,
// the channel interfaces, lbwe_timing and lbwe_ser.
module led_bit_waveform_encoder_top import lbwe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lbwe_in_if.sink    in_ch,
  lbwe_out_if.source out_ch,
  lbwe_cfg_if.sink   cfg_ch
);

  timing_t tim;

  lbwe_timing u_timing (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .tim   (tim)
  );

  lbwe_ser u_ser (
    .clk    (clk),
    .rst_n  (rst_n),
    .tim    (tim),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ----- rtl/lbwe_chk.sv -----
// Port-level checker for the LED bit waveform encoder and its bind to the
// top level. Depends on lbwe_pkg and the channel interfaces.
module lbwe_chk import lbwe_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  lbwe_in_if.sink    in_ch,
  lbwe_out_if.source out_ch,
  lbwe_cfg_if.sink   cfg_ch
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pulse_pattern)
      && $stable(out_ch.pulse_count) && $stable(out_ch.bit_value)
      && $stable(out_ch.last_of_byte) && $stable(out_ch.timing_error))
    else $error("output item changed while stalled");

  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.timing_error |-> out_ch.last_of_byte
      && out_ch.pulse_pattern == '0 && out_ch.pulse_count == '0 && !out_ch.bit_value)
    else $error("error item not empty");

  a_pattern_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.timing_error |-> out_ch.pulse_count != '0
      && out_ch.pulse_count <= COUNT_W'(PULSE_LIMIT)
      && (out_ch.pulse_pattern >> out_ch.pulse_count) == '0)
    else $error("pattern exceeds pulse count");

  a_cfg_recalc: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.ready |=> !in_ch.ready)
    else $error("input ready right after a register write");

  a_reset_recalc: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("input ready right after reset");

endmodule

bind led_bit_waveform_encoder_top lbwe_chk u_lbwe_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch),
  .cfg_ch (cfg_ch)
);

// ----- bench/led_bit_waveform_encoder_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for led_bit_waveform_encoder_top: drives bytes and timing settings,
// predicts the eight pulse patterns per byte, or one error item under a bad setting, and checks each result item.
// Depends on lbwe_pkg, the channel interfaces and the encoder RTL.
module led_bit_waveform_encoder_top_tb;
  import lbwe_pkg::*;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;
    logic [COUNT_W-1:0]   count;
    logic                 bit_value;
    logic                 last_of_byte;
    logic                 timing_error;
  } pattern_item_t;

  class pattern_scoreboard;
    logic [RATE_W-1:0]  rate_hz;
    logic [PHASE_W-1:0] first_ns;
    logic [PHASE_W-1:0] middle_ns;
    logic [PHASE_W-1:0] last_ns;
    logic [COUNT_W-1:0] ppb;
    logic [COUNT_W-1:0] zero_hi;
    logic [COUNT_W-1:0] one_hi;
    bit                 invalid;
    pattern_item_t      expected_patterns[$];
    int                 errors;

    function new();
      rate_hz   = RATE_RST;
      first_ns  = FIRST_RST;
      middle_ns = MIDDLE_RST;
      last_ns   = LAST_RST;
      errors    = 0;
      derive_counts();
    endfunction

    function void derive_counts();
      longint unsigned period, total, n, p1, p3;
      ppb     = '0;
      zero_hi = '0;
      one_hi  = '0;
      invalid = 1'b1;
      if (rate_hz == 0 || first_ns == 0 || middle_ns == 0 || last_ns == 0) return;
      period = 64'd1000000000 / rate_hz;
      if (period == 0) return;
      total = longint'(first_ns) + longint'(middle_ns) + longint'(last_ns);
      n = (total + period / 2) / period;
      if (n == 0 || n > MAX_PULSES_PER_BIT || n > PATTERN_W) return;
      p1 = (first_ns * n + total / 2) / total;
      p3 = (last_ns * n + total / 2) / total;
      if (p1 > n) p1 = n;
      if (p3 > n - p1) p3 = n - p1;
      ppb     = n[COUNT_W-1:0];
      zero_hi = p1[COUNT_W-1:0];
      one_hi  = COUNT_W'(n - p3);
      invalid = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        REG_RATE:   rate_hz   = value[RATE_W-1:0];
        REG_FIRST:  first_ns  = value[PHASE_W-1:0];
        REG_MIDDLE: middle_ns = value[PHASE_W-1:0];
        REG_LAST:   last_ns   = value[PHASE_W-1:0];
        default: ;
      endcase
      derive_counts();
    endfunction

    function void note_byte(logic [7:0] data_byte);
      pattern_item_t item;
      logic [5:0] highs;
      logic [63:0] mask;
      if (invalid) begin
        item = '0;
        item.last_of_byte = 1'b1;
        item.timing_error = 1'b1;
        expected_patterns.push_back(item);
        return;
      end
      for (int k = 0; k < 8; k++) begin
        item = '0;
        item.bit_value = data_byte[7-k];
        highs = item.bit_value ? one_hi : zero_hi;
        mask = (64'd1 << highs) - 64'd1;
        item.pattern = mask[PATTERN_W-1:0];
        item.count = ppb;
        item.last_of_byte = (k == 7);
        expected_patterns.push_back(item);
      end
    endfunction

    function int pending();
      return expected_patterns.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
    endtask

    task check_pattern(pattern_item_t got);
      pattern_item_t want;
      if (expected_patterns.size() == 0) begin
        report("item with nothing expected, pulse_pattern", got.pattern, 32'd0);
        return;
      end
      want = expected_patterns.pop_front();
      if (got.pattern !== want.pattern) report("pulse_pattern", got.pattern, want.pattern);
      if (got.count !== want.count)
        report("pulse_count", 32'(got.count), 32'(want.count));
      if (got.bit_value !== want.bit_value)
        report("bit_value", 32'(got.bit_value), 32'(want.bit_value));
      if (got.last_of_byte !== want.last_of_byte)
        report("last_of_byte", 32'(got.last_of_byte), 32'(want.last_of_byte));
      if (got.timing_error !== want.timing_error)
        report("timing_error", 32'(got.timing_error), 32'(want.timing_error));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   gaps_on;
  bit   hold_off_req;
  int   stall_left;
  pattern_scoreboard board;

  lbwe_in_if  in_ch ();
  lbwe_out_if out_ch ();
  lbwe_cfg_if cfg_ch ();

  led_bit_waveform_encoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    pattern_item_t got;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.pattern      = out_ch.pulse_pattern;
        got.count        = out_ch.pulse_count;
        got.bit_value    = out_ch.bit_value;
        got.last_of_byte = out_ch.last_of_byte;
        got.timing_error = out_ch.timing_error;
        board.check_pattern(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = 400;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 16);
      end
    end
  end

  task send_byte(input logic [7:0] data_byte);
    while (gaps_on && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data_byte;
    do @(posedge clk); while (!in_ch.ready);
    board.note_byte(data_byte);
  endtask

  task write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, value);
  endtask

  task apply_timing(input logic [RATE_W-1:0] rate_hz, input logic [PHASE_W-1:0] first_ns,
                    input logic [PHASE_W-1:0] middle_ns, input logic [PHASE_W-1:0] last_ns);
    write_reg(REG_RATE, rate_hz);
    write_reg(REG_FIRST, CFG_DAT_W'(first_ns));
    write_reg(REG_MIDDLE, CFG_DAT_W'(middle_ns));
    write_reg(REG_LAST, CFG_DAT_W'(last_ns));
    cfg_ch.valid <= 1'b0;
  endtask

  task wait_drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task pick_timing(output logic [RATE_W-1:0] rate_hz, output logic [PHASE_W-1:0] first_ns,
                   output logic [PHASE_W-1:0] middle_ns, output logic [PHASE_W-1:0] last_ns);
    int unsigned total, period, n;
    if ($urandom_range(7) == 0) begin
      rate_hz   = RATE_W'($urandom);
      first_ns  = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom);
      middle_ns = PHASE_W'($urandom);
      last_ns   = PHASE_W'($urandom);
    end else begin
      if ($urandom_range(3) == 0) begin
        first_ns  = PHASE_W'($urandom_range(1, 65535));
        middle_ns = PHASE_W'($urandom_range(1, 65535));
        last_ns   = PHASE_W'($urandom_range(1, 65535));
      end else begin
        first_ns  = PHASE_W'($urandom_range(1, 3000));
        middle_ns = PHASE_W'($urandom_range(1, 3000));
        last_ns   = PHASE_W'($urandom_range(1, 3000));
      end
      total  = first_ns + middle_ns + last_ns;
      n      = $urandom_range(1, 32);
      period = total / n;
      if (period == 0) period = 1;
      rate_hz = RATE_W'(1000000000 / period);
      if ($urandom_range(3) == 0)
        rate_hz = RATE_W'(rate_hz + $urandom_range(0, rate_hz / 8));
    end
  endtask

  function logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [RATE_W-1:0]  rate_hz;
    logic [PHASE_W-1:0] first_ns, middle_ns, last_ns;
    int random_sent, phase, nbytes;

    board = new();
    gaps_on = 1'b1;
    hold_off_req = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_RATE;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    wait_drain();
    // widest pattern: 32 pulses per bit
    apply_timing(30'd25600000, 16'd250, 16'd625, 16'd375);
    send_byte(8'h0F);
    send_byte(8'hF0);
    wait_drain();
    apply_timing(30'd1000000000, 16'd1, 16'd1, 16'd1);
    send_byte(8'h81);
    wait_drain();
    // single pulse per bit
    apply_timing(30'd1000000, 16'd1000, 16'd1, 16'd1);
    send_byte(8'h3C);
    wait_drain();
    apply_timing(30'd100000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_byte(8'hC3);
    wait_drain();
    apply_timing(30'd0, 16'd250, 16'd625, 16'd375);
    send_byte(8'h55);
    wait_drain();
    apply_timing(30'd10000000, 16'd0, 16'd625, 16'd375);
    send_byte(8'hAA);
    wait_drain();
    apply_timing(30'd10000000, 16'd250, 16'd0, 16'd375);
    send_byte(8'h01);
    wait_drain();
    apply_timing(30'd10000000, 16'd250, 16'd625, 16'd0);
    send_byte(8'h80);
    wait_drain();
    // rate above 1 GHz leaves no period
    apply_timing(30'h3FFFFFFF, 16'd250, 16'd625, 16'd375);
    send_byte(8'h7E);
    wait_drain();
    // too few and too many pulses per bit
    apply_timing(30'd1, 16'd250, 16'd625, 16'd375);
    send_byte(8'h18);
    wait_drain();
    apply_timing(30'd1000000000, 16'd250, 16'd625, 16'd375);
    send_byte(8'hE7);
    wait_drain();
    apply_timing(RATE_RST, FIRST_RST, MIDDLE_RST, LAST_RST);
    send_byte(8'h12);

    random_sent = 0;
    phase = 0;
    while (random_sent < 480) begin
      wait_drain();
      pick_timing(rate_hz, first_ns, middle_ns, last_ns);
      apply_timing(rate_hz, first_ns, middle_ns, last_ns);
      gaps_on = (phase != 2);
      if (phase == 1) hold_off_req = 1'b1;
      nbytes = board.invalid ? $urandom_range(4, 10) : $urandom_range(30, 60);
      for (int i = 0; i < nbytes; i++) begin
        if (phase == 3 && i == nbytes / 2) wait_drain();
        send_byte(pick_byte());
        random_sent++;
      end
      phase++;
    end
    gaps_on = 1'b1;
    wait_drain();
    repeat (20) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
